### rtl/core/uraeng_pkg.sv
`timescale 1ns / 1ps

package uraeng_pkg;

    // Input operation codes (carried on s_tuser)
    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_BYTE  = 2'd2,
        OP_TICK  = 2'd3
    } op_e_t;

    // Result kinds (carried on m_tuser)
    localparam logic [1:0] KIND_TX     = 2'd0;
    localparam logic [1:0] KIND_DATA   = 2'd1;
    localparam logic [1:0] KIND_STATUS = 2'd2;

    // Transaction status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_TIMEOUT = 2'd1;
    localparam logic [1:0] ST_REJECT  = 2'd2;

    // Protocol bytes
    localparam logic [7:0] START_BYTE   = 8'hAA;
    localparam logic [7:0] DIR_WRITE    = 8'h00;
    localparam logic [7:0] DIR_READ     = 8'h01;
    localparam logic [7:0] WR_LEN_BYTE  = 8'h01;
    localparam logic [7:0] ACK_HDR_BYTE = 8'hEE;
    localparam logic [7:0] ACK_OK_BYTE  = 8'h01;
    localparam logic [7:0] RD_HDR_BYTE  = 8'hBB;

    // Timeout register
    localparam int         TO_W          = 16;
    localparam logic [15:0] TIMEOUT_RESET = 16'd20;

    // Command queue between front and back
    localparam int Q_PTR_W = 2;
    localparam int Q_DEPTH = 1 << Q_PTR_W;

    // Engine phase
    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_WR_ACK  = 2'd1,
        PH_RD_HDR  = 2'd2,
        PH_RD_DATA = 2'd3
    } phase_t;

    // Command kinds queued for the back end
    typedef enum logic [1:0] {
        CMD_WRITE  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_DATA   = 2'd2,
        CMD_STATUS = 2'd3
    } cmd_kind_t;

    // One queued command: a = addr / data byte / status, b = wdata / len
    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] a;
        logic [7:0] b;
        logic       last;
    } cmd_t;

endpackage

### rtl/core/uraeng_fifo.sv
`timescale 1ns / 1ps

module uraeng_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  uraeng_pkg::cmd_t    push_cmd,
    output logic                full,
    input  logic                pop,
    output uraeng_pkg::cmd_t    head_cmd,
    output logic                empty
);
    import uraeng_pkg::*;

    cmd_t                q_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]  wr_ptr_reg;
    logic [Q_PTR_W-1:0]  wr_ptr_next;
    logic [Q_PTR_W-1:0]  rd_ptr_reg;
    logic [Q_PTR_W-1:0]  rd_ptr_next;
    logic [Q_PTR_W:0]    count_reg;
    logic [Q_PTR_W:0]    count_next;

    assign full     = (count_reg == (Q_PTR_W+1)'(Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = q_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/core/uraeng_front.sv
`timescale 1ns / 1ps

module uraeng_front #(
    parameter int TIMER_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [1:0]          s_tuser,
    input  logic [31:0]         s_tdata,
    input  logic                cfg_we,
    input  logic [15:0]         cfg_wdata,
    input  logic                q_full,
    output logic                push,
    output uraeng_pkg::cmd_t    push_cmd
);
    import uraeng_pkg::*;

    localparam int CMP_W = (TIMER_BITS > TO_W) ? TIMER_BITS : TO_W;

    phase_t                 phase_reg;
    phase_t                 phase_next;
    logic [7:0]             exp_len_reg;
    logic [7:0]             exp_len_next;
    logic [7:0]             seen_reg;
    logic [7:0]             seen_next;
    logic [TIMER_BITS-1:0]  timer_reg;
    logic [TIMER_BITS-1:0]  timer_next;
    logic [7:0]             hdr_reg;
    logic [7:0]             hdr_next;
    logic [TO_W-1:0]        timeout_reg;

    logic                   accept;
    op_e_t                  op;
    logic [7:0]             reg_addr;
    logic [7:0]             write_data;
    logic [7:0]             read_len;
    logic [7:0]             rx_byte;
    logic [TIMER_BITS-1:0]  timer_inc;
    logic                   timed_out;
    logic [7:0]             seen_inc;

    assign s_tready   = !q_full;
    assign accept     = s_tvalid && s_tready;
    assign op         = op_e_t'(s_tuser);
    assign reg_addr   = s_tdata[7:0];
    assign write_data = s_tdata[15:8];
    assign read_len   = s_tdata[23:16];
    assign rx_byte    = s_tdata[31:24];

    // timeout check: saturated count, or incremented count above the limit
    assign timer_inc = timer_reg + 1'b1;
    assign timed_out = (&timer_reg) || (CMP_W'(timer_inc) > CMP_W'(timeout_reg));
    assign seen_inc  = seen_reg + 8'd1;

    // timeout register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            timeout_reg <= cfg_wdata;
        end
    end

    // protocol state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            exp_len_reg <= '0;
            seen_reg    <= '0;
            timer_reg   <= '0;
            hdr_reg     <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            exp_len_reg <= exp_len_next;
            seen_reg    <= seen_next;
            timer_reg   <= timer_next;
            hdr_reg     <= hdr_next;
        end
    end

    // classify the item, update state, queue a command
    always_comb
    begin
        phase_next   = phase_reg;
        exp_len_next = exp_len_reg;
        seen_next    = seen_reg;
        timer_next   = timer_reg;
        hdr_next     = hdr_reg;
        push         = 1'b0;
        push_cmd     = '{kind: CMD_STATUS, a: 8'd0, b: 8'd0, last: 1'b1};

        if (accept)
        begin
            unique case (op)
                OP_WRITE, OP_READ:
                begin
                    if (phase_reg == PH_IDLE)
                    begin
                        push       = 1'b1;
                        seen_next  = '0;
                        timer_next = '0;
                        push_cmd.a = reg_addr;
                        if (op == OP_WRITE)
                        begin
                            push_cmd.kind = CMD_WRITE;
                            push_cmd.b    = write_data;
                            phase_next    = PH_WR_ACK;
                        end
                        else
                        begin
                            push_cmd.kind = CMD_READ;
                            push_cmd.b    = read_len;
                            exp_len_next  = read_len;
                            phase_next    = PH_RD_HDR;
                        end
                    end
                end
                OP_TICK:
                begin
                    if (phase_reg != PH_IDLE)
                    begin
                        if (timed_out)
                        begin
                            push       = 1'b1;
                            push_cmd.a = {6'd0, ST_TIMEOUT};
                            phase_next = PH_IDLE;
                            seen_next  = '0;
                            timer_next = '0;
                        end
                        else
                        begin
                            timer_next = timer_inc;
                        end
                    end
                end
                OP_BYTE:
                begin
                    unique case (phase_reg)
                        PH_IDLE:
                        begin
                        end
                        PH_WR_ACK, PH_RD_HDR:
                        begin
                            if (seen_reg == 8'd0)
                            begin
                                hdr_next  = rx_byte;
                                seen_next = 8'd1;
                            end
                            else if (phase_reg == PH_WR_ACK)
                            begin
                                push       = 1'b1;
                                push_cmd.a = {6'd0,
                                    ((hdr_reg == ACK_HDR_BYTE) && (rx_byte == ACK_OK_BYTE))
                                    ? ST_OK : ST_REJECT};
                                phase_next = PH_IDLE;
                                seen_next  = '0;
                                timer_next = '0;
                            end
                            else if ((hdr_reg != RD_HDR_BYTE) || (rx_byte != exp_len_reg))
                            begin
                                push       = 1'b1;
                                push_cmd.a = {6'd0, ST_REJECT};
                                phase_next = PH_IDLE;
                                seen_next  = '0;
                                timer_next = '0;
                            end
                            else if (exp_len_reg == 8'd0)
                            begin
                                push       = 1'b1;
                                push_cmd.a = {6'd0, ST_OK};
                                phase_next = PH_IDLE;
                                seen_next  = '0;
                                timer_next = '0;
                            end
                            else
                            begin
                                // header accepted, restart the wait
                                phase_next = PH_RD_DATA;
                                seen_next  = '0;
                                timer_next = '0;
                            end
                        end
                        PH_RD_DATA:
                        begin
                            push          = 1'b1;
                            push_cmd.kind = CMD_DATA;
                            push_cmd.a    = rx_byte;
                            if (seen_inc == exp_len_reg)
                            begin
                                push_cmd.last = 1'b1;
                                phase_next    = PH_IDLE;
                                seen_next     = '0;
                                timer_next    = '0;
                            end
                            else
                            begin
                                push_cmd.last = 1'b0;
                                seen_next     = seen_inc;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    // a command is only queued for an accepted item, never into a full queue
    a_push_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (accept && !q_full))
        else $error("command queued without an accepted item");

    // idle engine keeps its wait timer cleared
    a_idle_timer: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (timer_reg == '0))
        else $error("wait timer nonzero while idle");

    // data phase only entered with a nonzero length
    a_data_len: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_RD_DATA) |-> (exp_len_reg != 8'd0))
        else $error("data phase with zero length");

    // header phases see at most one stored header byte
    a_hdr_count: assert property (@(posedge clk) disable iff (!rst_n)
        ((phase_reg == PH_WR_ACK) || (phase_reg == PH_RD_HDR)) |-> (seen_reg <= 8'd1))
        else $error("header byte count out of range");

endmodule

### rtl/core/uraeng_back.sv
`timescale 1ns / 1ps

module uraeng_back (
    input  logic                clk,
    input  logic                rst_n,
    input  uraeng_pkg::cmd_t    head_cmd,
    input  logic                q_empty,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [1:0]          m_tuser,
    output logic [15:0]         m_tdata,
    output logic                m_tlast
);
    import uraeng_pkg::*;

    logic [2:0] idx_reg;
    logic [2:0] idx_next;
    logic [7:0] value;
    logic [1:0] status;
    logic       last_item;
    logic       out_acc;

    assign m_tvalid = !q_empty;
    assign out_acc  = m_tvalid && m_tready;
    assign pop      = out_acc && last_item;
    assign m_tdata  = {6'd0, status, value};

    // expand the head command into output items
    always_comb
    begin
        m_tuser   = KIND_TX;
        value     = 8'd0;
        status    = ST_OK;
        m_tlast   = 1'b0;
        last_item = 1'b1;
        unique case (head_cmd.kind)
            CMD_WRITE:
            begin
                last_item = (idx_reg == 3'd4);
                m_tlast   = last_item;
                unique case (idx_reg)
                    3'd0:    value = START_BYTE;
                    3'd1:    value = DIR_WRITE;
                    3'd2:    value = head_cmd.a;
                    3'd3:    value = WR_LEN_BYTE;
                    default: value = head_cmd.b;
                endcase
            end
            CMD_READ:
            begin
                last_item = (idx_reg == 3'd3);
                m_tlast   = last_item;
                unique case (idx_reg)
                    3'd0:    value = START_BYTE;
                    3'd1:    value = DIR_READ;
                    3'd2:    value = head_cmd.a;
                    default: value = head_cmd.b;
                endcase
            end
            CMD_DATA:
            begin
                m_tuser = KIND_DATA;
                value   = head_cmd.a;
                m_tlast = head_cmd.last;
            end
            CMD_STATUS:
            begin
                m_tuser = KIND_STATUS;
                status  = head_cmd.a[1:0];
                m_tlast = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // position within the current command
    always_comb
    begin
        idx_next = idx_reg;
        if (pop)
        begin
            idx_next = '0;
        end
        else if (out_acc)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

### rtl/core/uart_register_access_engine_unit.sv
`timescale 1ns / 1ps

// Channel   Dir  Handshake            Payload
// s_*       in   s_tvalid/s_tready    tuser: op; tdata: reg_addr, write_data, read_len, rx_byte
// m_*       out  m_tvalid/m_tready    tuser: kind; tdata: value, status; tlast: last
// cfg_*     in   cfg_we               cfg_wdata: timeout_ticks
//
// An input item is taken every cycle while the 4-entry command queue has room.
// A write request yields 5 output items, a read request 4, other results 1;
// the back end sends one output item per cycle while m_tready is high, so its output rate sets the pace.
// An accepted input item's command is registered in the command queue before its first output item is sent.
// rst_n clears protocol state and the queue at once; timeout_ticks resets to 20.
// A stalled output fills the queue; s_tready drops only when the queue is full.

module uart_register_access_engine_unit #(
    parameter int TIMER_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [1:0]  s_tuser,    // op
    input  logic [31:0] s_tdata,    // reg_addr, write_data, read_len, rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,    // kind
    output logic [15:0] m_tdata,    // value, status, zero pad
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata   // timeout_ticks
);
    import uraeng_pkg::*;

    cmd_t push_cmd;
    cmd_t head_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_empty;

    uraeng_front #(
        .TIMER_BITS (TIMER_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    uraeng_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .head_cmd (head_cmd),
        .empty    (q_empty)
    );

    uraeng_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head_cmd (head_cmd),
        .q_empty  (q_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
